### src/permutation_rank_unrank_unit_macros.svh
// ----------------------------------------------------------------------------
// permutation rank / unrank unit assertion macros
// shared concurrent assertion forms for the rank / unrank datapath
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_RANK_UNRANK_UNIT_MACROS_SVH
`define PERMUTATION_RANK_UNRANK_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define PRRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define PRRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/prru_pkg.sv
// ----------------------------------------------------------------------------
// prru_pkg
// widths, item types and the factorial helper of the rank / unrank unit
// ----------------------------------------------------------------------------
package prru_pkg;

	localparam int ELEM_W      = 3;
	localparam int RANK_W      = 13;
	localparam int DIG_W       = 3;
	localparam int MAX_SYM     = 7;
	localparam int SYMBOLS_DEF = 7;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [MAX_SYM-1:0][ELEM_W-1:0] elem_vec_t;

	typedef struct packed {
		logic  req_type;
		rank_t rank_in;
		elem_t elem_in_0;
		elem_t elem_in_1;
		elem_t elem_in_2;
		elem_t elem_in_3;
		elem_t elem_in_4;
		elem_t elem_in_5;
		elem_t elem_in_6;
	} req_t;

	typedef struct packed {
		rank_t rank_out;
		elem_t elem_out_0;
		elem_t elem_out_1;
		elem_t elem_out_2;
		elem_t elem_out_3;
		elem_t elem_out_4;
		elem_t elem_out_5;
		elem_t elem_out_6;
		logic  rank_too_big;
	} rsp_t;

	// what travels from cell to cell
	typedef struct packed {
		logic      unrank;
		logic      too_big;
		rank_t     rem;
		rank_t     acc;
		elem_vec_t elem_in;
		elem_vec_t avail;
		elem_vec_t elem_out;
	} cell_data_t;

	function automatic int fact(input int n);
		int f;
		f = 1;
		for (int k = 2; k <= n; k++) begin
			f = f * k;
		end
		return f;
	endfunction

endpackage

### src/prru_chan_if.sv
// ----------------------------------------------------------------------------
// prru_chan_if
// valid / ready channel carrying one item of payload type T
// ----------------------------------------------------------------------------
interface prru_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/prru_cell.sv
// ----------------------------------------------------------------------------
// prru_cell
// one position of the chain: adds its weighted smaller-count when ranking,
// takes one factorial digit and picks a free symbol when unranking
// ----------------------------------------------------------------------------
`include "permutation_rank_unrank_unit_macros.svh"

module prru_cell import prru_pkg::*; #(
	parameter int SYMS = SYMBOLS_DEF,
	parameter int POS  = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cell_data_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output cell_data_t out_data
);

	localparam int    LEFT   = SYMS - POS;
	localparam rank_t WEIGHT = RANK_W'(fact(SYMS - 1 - POS));

	logic             valid_s1;
	cell_data_t       data_s1;
	cell_data_t       nxt;
	logic [DIG_W-1:0] cnt;
	logic [DIG_W-1:0] digit;

	always_comb begin
		nxt   = in_data;
		cnt   = '0;
		digit = '0;
		// later symbols that are smaller
		for (int j = 0; j < MAX_SYM; j++) begin
			if (j > POS && j < SYMS && in_data.elem_in[j] < in_data.elem_in[POS]) begin
				cnt = cnt + DIG_W'(1);
			end
		end
		// factorial digit by comparing against its multiples
		for (int k = 1; k < MAX_SYM; k++) begin
			if (k < LEFT && in_data.rem >= RANK_W'(k * WEIGHT)) begin
				digit = digit + DIG_W'(1);
			end
		end
		if (!in_data.unrank) begin
			nxt.acc = in_data.acc + RANK_W'(cnt) * WEIGHT;
		end
		nxt.rem           = in_data.rem - RANK_W'(digit) * WEIGHT;
		nxt.elem_out[POS] = in_data.avail[digit];
		// close the gap left by the symbol just used
		for (int k = 0; k < MAX_SYM - 1; k++) begin
			nxt.avail[k] = (DIG_W'(k) >= digit) ? in_data.avail[k+1] : in_data.avail[k];
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	`PRRU_ASSERT_NXT(a_item_held, clk, arst_n, in_valid && in_ready, valid_s1, "cell lost an item")
	`PRRU_ASSERT_NOW(a_digit_range, clk, arst_n, in_valid, 32'(digit) < LEFT, "digit beyond free list")
	`PRRU_ASSERT_NOW(a_rem_range, clk, arst_n, in_valid, nxt.rem < WEIGHT, "remainder not reduced")

endmodule

### src/permutation_rank_unrank_unit.sv
// ----------------------------------------------------------------------------
// permutation_rank_unrank_unit
// Converts between a permutation of SYMBOLS symbols and its lexicographic
// rank. An item enters on req and its result leaves on rsp; a new item is
// taken every cycle while rsp does not stall, since the work runs through a
// chain of SYMBOLS cells, one per position, each ending in a register stage,
// and the last stage is the output register. A stall on rsp backs up the
// chain stage by stage; req.ready follows combinationally from the free
// stages. A rank request gives rank_out and zero symbols; an unrank request
// gives the symbols, and a rank of SYMBOLS! or more gives the identity with
// rank_too_big set. Symbols to rank are not checked for being a permutation.
// ----------------------------------------------------------------------------
`include "permutation_rank_unrank_unit_macros.svh"

module permutation_rank_unrank_unit import prru_pkg::*; #(
	parameter int SYMBOLS = SYMBOLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	prru_chan_if.sink   req,
	prru_chan_if.source rsp
);

	localparam rank_t MAX_RANK = RANK_W'(fact(SYMBOLS));

	logic [SYMBOLS:0] link_valid;
	logic [SYMBOLS:0] link_ready;
	cell_data_t       link_data [SYMBOLS+1];
	cell_data_t       entry;
	cell_data_t       last;
	rsp_t             result;

	always_comb begin
		entry             = '0;
		entry.unrank      = req.data.req_type;
		entry.too_big     = req.data.req_type && (req.data.rank_in >= MAX_RANK);
		// an oversize rank unranks as zero, which is the identity
		entry.rem         = (req.data.req_type && !entry.too_big) ? req.data.rank_in : '0;
		entry.elem_in[0]  = req.data.elem_in_0;
		entry.elem_in[1]  = req.data.elem_in_1;
		entry.elem_in[2]  = req.data.elem_in_2;
		entry.elem_in[3]  = req.data.elem_in_3;
		entry.elem_in[4]  = req.data.elem_in_4;
		entry.elem_in[5]  = req.data.elem_in_5;
		entry.elem_in[6]  = req.data.elem_in_6;
		for (int k = 0; k < MAX_SYM; k++) begin
			entry.avail[k] = ELEM_W'(k);
		end
	end

	assign link_valid[0] = req.valid;
	assign req.ready     = link_ready[0];
	assign link_data[0]  = entry;

	for (genvar i = 0; i < SYMBOLS; i++) begin : g_cell
		prru_cell #(
			.SYMS (SYMBOLS),
			.POS  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	assign last                = link_data[SYMBOLS];
	assign rsp.valid           = link_valid[SYMBOLS];
	assign link_ready[SYMBOLS] = rsp.ready;

	always_comb begin
		result              = '0;
		result.rank_too_big = last.too_big;
		if (last.unrank) begin
			result.elem_out_0 = last.elem_out[0];
			result.elem_out_1 = last.elem_out[1];
			result.elem_out_2 = last.elem_out[2];
			result.elem_out_3 = last.elem_out[3];
			result.elem_out_4 = last.elem_out[4];
			result.elem_out_5 = last.elem_out[5];
			result.elem_out_6 = last.elem_out[6];
		end else begin
			result.rank_out = last.acc;
		end
	end

	assign rsp.data = result;

	`PRRU_ASSERT_NOW(a_big_identity, clk, arst_n, rsp.valid && result.rank_too_big, result.rank_out == '0 && result.elem_out_0 == '0 && result.elem_out_1 == ELEM_W'(1), "oversize rank not identity")
	`PRRU_ASSERT_NOW(a_rank_no_elems, clk, arst_n, rsp.valid && !last.unrank, result.elem_out_0 == '0 && result.elem_out_6 == '0 && !result.rank_too_big, "rank result carries symbols")
	`PRRU_ASSERT_NOW(a_rank_bound, clk, arst_n, rsp.valid, result.rank_out < MAX_RANK, "rank out of range")

endmodule
